// ----- design/tfd_pkg.sv -----
`default_nettype none

package tfd_pkg;

   // Frame layout
   localparam int unsigned BODY_LEN = 21;
   localparam int unsigned XOR_LEN  = 18;
   localparam int unsigned IDX_W    = 5;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BODY_LEN - 1);
   localparam logic [IDX_W-1:0] XOR_END  = IDX_W'(XOR_LEN);

   // Framing bytes
   localparam logic [7:0] HDR_FIRST   = 8'hFA;
   localparam logic [7:0] HDR_SECOND  = 8'hAA;
   localparam logic [7:0] TAIL_FIRST  = 8'hAF;
   localparam logic [7:0] TAIL_SECOND = 8'h55;

   // Hunt state, one-hot
   typedef enum logic [2:0] {
      PH_WAIT_FIRST  = 3'b001,
      PH_WAIT_SECOND = 3'b010,
      PH_BODY        = 3'b100
   } phase_type;

   // Decoded frame
   typedef struct packed {
      logic               frame_good;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] mount_yaw;
      logic signed [31:0] mount_pitch;
      logic [7:0]         confidence;
      logic               target_active;
   } result_type;

endpackage

`default_nettype wire

// ----- design/tfd_parser.sv -----
`default_nettype none

module tfd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,
   input  wire logic [7:0]         rx_byte,
   output logic                    done,
   output tfd_pkg::result_type     result
);
   import tfd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       store_ff [BODY_LEN];
   logic             in_body;

   assign in_body = (phase_ff == PH_BODY);
   assign done    = take && in_body && (index_ff == LAST_IDX);

   // Advance hunt state, body position and checksum
   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      xor_in   = xor_ff;
      if (take) begin
         unique case (phase_ff)
            PH_WAIT_FIRST: begin
               if (rx_byte == HDR_FIRST) phase_in = PH_WAIT_SECOND;
            end
            PH_WAIT_SECOND: begin
               if (rx_byte == HDR_SECOND) begin
                  phase_in = PH_BODY;
                  index_in = '0;
                  xor_in   = '0;
               end else if (rx_byte != HDR_FIRST) begin
                  phase_in = PH_WAIT_FIRST;
               end
            end
            PH_BODY: begin
               if (index_ff < XOR_END) xor_in = xor_ff ^ rx_byte;
               if (index_ff == LAST_IDX) begin
                  phase_in = PH_WAIT_FIRST;
                  index_in = '0;
                  xor_in   = '0;
               end else begin
                  index_in = index_ff + IDX_W'(1);
               end
            end
            default: begin
               phase_in = PH_WAIT_FIRST;
               index_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_FIRST;
         index_ff <= '0;
         xor_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
      end
   end

   // Store body bytes at the current position
   always_ff @(posedge clock) begin
      if (take && in_body) store_ff[index_ff] <= rx_byte;
   end

   // Decode the frame; the last tail byte is the one arriving now
   always_comb begin
      result.frame_good    = (store_ff[19] == TAIL_FIRST) && (rx_byte == TAIL_SECOND) &&
                             (xor_ff == store_ff[18]);
      result.target_x      = {store_ff[3],  store_ff[2],  store_ff[1],  store_ff[0]};
      result.target_y      = {store_ff[7],  store_ff[6],  store_ff[5],  store_ff[4]};
      result.mount_yaw     = {store_ff[11], store_ff[10], store_ff[9],  store_ff[8]};
      result.mount_pitch   = {store_ff[15], store_ff[14], store_ff[13], store_ff[12]};
      result.confidence    = store_ff[16];
      result.target_active = (store_ff[17] != 8'h00);
   end

endmodule

`default_nettype wire

// ----- design/tfd_out_reg.sv -----
`default_nettype none

module tfd_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire tfd_pkg::result_type load_data,
   input  wire logic                out_stall,
   output logic                     out_valid,
   output logic                     free,
   output tfd_pkg::result_type      out_data
);
   import tfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Slot frees up when empty or when its transfer completes this cycle
   assign free     = !valid_ff || !out_stall;
   assign valid_in = load || (valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // Hold payload while stalled
   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- design/target_frame_deframer.sv -----
// Serial frame deframer with XOR checksum.
// Input channel (req_): one received byte per transfer on req_rx_byte.
// The block hunts for header FA AA (a repeated FA keeps waiting for AA),
// collects a 21-byte body, and emits one result per completed body.
// Result channel (rsp_): frame_good plus four little-endian signed words,
// the confidence byte and the active flag. Data fields carry the body even
// when frame_good is 0 (bad checksum or tail).
// Output: the result is registered and appears in the cycle after the last body byte is taken.
// Throughput: one byte per cycle while req_stall is low; a new byte may enter
// in the same cycle a held result transfers, since parsing and decode are
// combinational between the hunt state and the single output register.
// Stall: req_stall rises only when a result is held and rsp_stall is high;
// bytes that produce no result then also wait.
// Reset: synchronous; returns to header hunt with the output empty.
`default_nettype none

module target_frame_deframer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_rx_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_frame_good,
   output logic signed [31:0]      rsp_target_x,
   output logic signed [31:0]      rsp_target_y,
   output logic signed [31:0]      rsp_mount_yaw,
   output logic signed [31:0]      rsp_mount_pitch,
   output logic [7:0]              rsp_confidence,
   output logic                    rsp_target_active
);
   import tfd_pkg::*;

   logic       take;
   logic       done;
   logic       free;
   result_type result;
   result_type out_data;

   assign req_stall = !free;
   assign take      = req_valid && free;

   tfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .done    (done),
      .result  (result)
   );

   tfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (done),
      .load_data (result),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .free      (free),
      .out_data  (out_data)
   );

   assign rsp_frame_good    = out_data.frame_good;
   assign rsp_target_x      = out_data.target_x;
   assign rsp_target_y      = out_data.target_y;
   assign rsp_mount_yaw     = out_data.mount_yaw;
   assign rsp_mount_pitch   = out_data.mount_pitch;
   assign rsp_confidence    = out_data.confidence;
   assign rsp_target_active = out_data.target_active;

`ifndef SYNTHESIS
   a_stall_needs_held_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_result_from_transfer: assert property (@(posedge clock) disable iff (reset)
      done |-> (req_valid && !req_stall))
      else $error("frame completed without an input transfer");

   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !done) |=> !rsp_valid)
      else $error("result repeated after its transfer");

   a_result_appears: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid)
      else $error("completed frame lost");
`endif

endmodule

`default_nettype wire
